[rtl/tawac_pkg.sv]
package tawac_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [17:0] tile_number;
    logic [15:0] avg_red;
    logic [15:0] avg_green;
    logic [15:0] avg_blue;
    logic        fully_transparent;
    logic        final_tile;
  } result_t;

  localparam int unsigned CfgW = 13;
  localparam logic [2:0] RegImageWidth  = 3'd0;
  localparam logic [2:0] RegImageHeight = 3'd1;
  localparam logic [2:0] RegTileWidth   = 3'd2;
  localparam logic [2:0] RegTileHeight  = 3'd3;
  localparam logic [2:0] RegTileColumns = 3'd4;

  localparam logic [15:0] HalfGray = 16'd32640;

  // Sum widths: enough for 256x256 tiles of full-scale pixels
  localparam int unsigned CSumW = 32;
  localparam int unsigned ASumW = 24;
  localparam int unsigned DivW  = CSumW + 8;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StAccum,
    StDivide,
    StOutput,
    StClear
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // register the incoming pixel and its position
    logic read_sums;  // registered read of the column's sums
    logic write_sums; // write back the updated sums
    logic clear_col;  // write zero to the column when its tile closes
    logic div_start;  // load the divider
    logic div_step;   // one restoring step
    logic load_out;   // fill the output register
    logic clear_step; // one entry of the clearing pass
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_tiles;  // captured pixel falls in a whole tile
    logic tile_done; // captured pixel closes its tile
    logic zero_reg;  // some register is zero
    logic div_done;
    logic clear_done;
  } dp_status_t;

endpackage

[rtl/tile_alpha_weighted_average_color.sv]
// Alpha-weighted tile average colour.
// Pixel requests arrive in raster order on in_valid_i/in_stall_o carrying
// RGBA; a request is taken at an edge with valid high and stall low.
// Result requests leave on out_valid_o/out_stall_i: tile number, Q8.8
// averages per channel, a transparent flag and a final-tile flag.
// A pixel that closes no tile passes capture, sum read and write back;
// a pixel outside the whole tiles is captured with no sum read. A tile-closing
// pixel runs the shared three-channel restoring divider, 40 steps (none for a
// transparent tile), then loads the output register. The single sums port
// serialises each pixel. With any register at zero each pixel is taken and
// dropped. The output register lets the next pixels proceed while a result
// waits; a second result holds in the controller until the receiver takes
// the first. After reset, and after any register write, a clearing pass
// zeroes the sums; no pixel is taken meanwhile. Configuration is written
// through cfg_we_i/cfg_index_i/cfg_data_i; the user must write it only while
// idle, which the block itself does not enforce.
module tile_alpha_weighted_average_color #(
  parameter int unsigned MAX_TILE_COLUMNS = 64,
  parameter int unsigned MAX_TILE_SIDE    = 256,
  parameter int unsigned MAX_IMAGE_SIDE   = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tawac_pkg::pixel_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tawac_pkg::result_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [12:0]        cfg_data_i
);
  import tawac_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  tawac_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cfg_hit_i(cfg_we_i && (cfg_index_i <= RegTileColumns)),
    .status_i(status), .cmd_o(cmd)
  );

  tawac_datapath #(
    .MaxTileColumns(MAX_TILE_COLUMNS),
    .MaxTileSide(MAX_TILE_SIDE),
    .MaxImageSide(MAX_IMAGE_SIDE)
  ) u_dp (
    .clk_i, .rst_ni, .pixel_i(in_data_i), .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .cmd_i(cmd), .status_o(status), .result_o(out_data_o)
  );
endmodule

[rtl/tawac_datapath.sv]
module tawac_datapath #(
  parameter int unsigned MaxTileColumns = 64,
  parameter int unsigned MaxTileSide    = 256,
  parameter int unsigned MaxImageSide   = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tawac_pkg::pixel_t   pixel_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [12:0]         cfg_data_i,
  input  tawac_pkg::dp_cmd_t  cmd_i,
  output tawac_pkg::dp_status_t status_o,
  output tawac_pkg::result_t  result_o
);
  import tawac_pkg::*;

  localparam int unsigned ColW = (MaxTileColumns > 1) ? $clog2(MaxTileColumns) : 1;
  localparam int unsigned PosW = $clog2(MaxImageSide + 1);

  // Configuration registers
  logic [12:0] img_w_q, img_h_q;
  logic [8:0]  tile_w_q, tile_h_q;
  logic [6:0]  cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q  <= 13'd16;
      img_h_q  <= 13'd16;
      tile_w_q <= 9'd16;
      tile_h_q <= 9'd16;
      cols_q   <= 7'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegImageWidth:  img_w_q  <= cfg_data_i;
        RegImageHeight: img_h_q  <= cfg_data_i;
        RegTileWidth:   tile_w_q <= cfg_data_i[8:0];
        RegTileHeight:  tile_h_q <= cfg_data_i[8:0];
        RegTileColumns: cols_q   <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Saturated register values
  logic [13:0] w, h;
  logic [10:0] tw, th;
  logic [8:0]  nc;
  always_comb begin
    w  = (32'(img_w_q) > MaxImageSide) ? 14'(MaxImageSide) : 14'(img_w_q);
    h  = (32'(img_h_q) > MaxImageSide) ? 14'(MaxImageSide) : 14'(img_h_q);
    tw = (11'(tile_w_q) > 11'(MaxTileSide)) ? 11'(MaxTileSide) : 11'(tile_w_q);
    th = (11'(tile_h_q) > 11'(MaxTileSide)) ? 11'(MaxTileSide) : 11'(tile_h_q);
    nc = (9'(cols_q) > 9'(MaxTileColumns)) ? 9'(MaxTileColumns) : 9'(cols_q);
  end
  assign status_o.zero_reg = (w == '0) || (h == '0) || (tw == '0) || (th == '0) ||
                             (nc == '0);

  // Position state: x, tile column, offset in tile, y, offset in tile row
  logic [PosW-1:0] x_q, y_q;
  logic [10:0]     xin_q, yin_q;
  logic [PosW-1:0] tx_q;
  logic [17:0]     row_base_q;
  logic            cfg_hit;
  assign cfg_hit = cfg_we_i && (cfg_index_i <= RegTileColumns);

  // Whole tile rows: a row counts only if its last line lies inside the image
  // (checked for each pixel from y_q, yin_q and th through row_end)
  logic last_row_line, last_img_line, last_x, in_tiles, tile_end;
  assign last_x        = (14'(x_q) + 14'd1 >= w);
  assign last_row_line = (yin_q == th - 11'd1);
  assign last_img_line = (14'(y_q) + 14'd1 >= h);
  // the tile row is whole iff its last line y_q - yin_q + th - 1 < h
  logic [14:0] row_end;
  assign row_end  = 15'(y_q) - 15'(yin_q) + 15'(th) - 15'd1;
  assign in_tiles = (15'(tx_q) < 15'(nc)) && (row_end < 15'(h));
  assign tile_end = ((xin_q == tw - 11'd1) || last_x) && last_row_line;

  // Final tile: whole rows end where next row would not fit; last column reached
  logic [14:0] next_row_end;
  logic        last_tile_row, last_col;
  assign next_row_end  = row_end + 15'(th);
  assign last_tile_row = next_row_end >= 15'(h);
  assign last_col      = (15'(tx_q) + 15'd1 == 15'(nc)) || last_x;

  // Captured request
  pixel_t           pix_q;
  logic [ColW-1:0]  col_q;
  logic             fin_q;
  logic [17:0]      tnum_q;
  logic             in_q, end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0; y_q <= '0; xin_q <= '0; yin_q <= '0;
      tx_q <= '0; row_base_q <= '0;
      in_q <= 1'b0; end_q <= 1'b0;
    end else if (cfg_hit) begin
      x_q <= '0; y_q <= '0; xin_q <= '0; yin_q <= '0;
      tx_q <= '0; row_base_q <= '0;
      in_q <= 1'b0; end_q <= 1'b0;
    end else if (cmd_i.capture) begin
      in_q <= in_tiles;
      end_q <= tile_end;
      if (last_x) begin
        x_q <= '0; xin_q <= '0; tx_q <= '0;
        if (last_img_line) begin
          y_q <= '0; yin_q <= '0; row_base_q <= '0;
        end else begin
          y_q <= y_q + 1'b1;
          if (last_row_line) begin
            yin_q <= '0;
            row_base_q <= row_base_q + 18'(nc);
          end else begin
            yin_q <= yin_q + 11'd1;
          end
        end
      end else begin
        x_q <= x_q + 1'b1;
        if (xin_q == tw - 11'd1) begin
          xin_q <= '0; tx_q <= tx_q + 1'b1;
        end else begin
          xin_q <= xin_q + 11'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pix_q  <= pixel_i;
      col_q  <= tx_q[ColW-1:0];
      fin_q  <= last_tile_row && last_col;
      tnum_q <= row_base_q + 18'(tx_q);
    end
  end
  assign status_o.in_tiles  = in_q;
  assign status_o.tile_done = end_q;

  // Per-column sums memory, with clearing pass
  logic [CSumW*3+ASumW-1:0] mem_q [MaxTileColumns];
  logic [CSumW*3+ASumW-1:0] rd_q, wr_data;
  logic [ColW-1:0]          clr_q;
  logic                     we;
  logic [ColW-1:0]          waddr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clear_step) clr_q <= clr_q + 1'b1;
  end
  assign status_o.clear_done = (32'(clr_q) == MaxTileColumns - 1);

  // Registered sums plus combinational products
  logic [CSumW-1:0] rs, gs, bs;
  logic [ASumW-1:0] as_;
  assign {rs, gs, bs, as_} = rd_q;
  logic [CSumW-1:0] rn, gn, bn;
  logic [ASumW-1:0] an;
  assign rn = rs + CSumW'({8'd0, pix_q.red} * {8'd0, pix_q.alpha});
  assign gn = gs + CSumW'({8'd0, pix_q.green} * {8'd0, pix_q.alpha});
  assign bn = bs + CSumW'({8'd0, pix_q.blue} * {8'd0, pix_q.alpha});
  assign an = as_ + ASumW'(pix_q.alpha);

  assign we      = cmd_i.write_sums || cmd_i.clear_col || cmd_i.clear_step;
  assign waddr   = cmd_i.clear_step ? clr_q : col_q;
  assign wr_data = cmd_i.write_sums ? {rn, gn, bn, an} : '0;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wr_data;
    if (cmd_i.read_sums) rd_q <= mem_q[col_q];
  end

  // Three-channel restoring divider: (sum << 8) / asum, one bit a cycle
  logic [DivW-1:0]  qr_q, qg_q, qb_q;
  logic [ASumW:0]   pr_q, pg_q, pb_q;
  logic [ASumW-1:0] den_q;
  logic [5:0]       cnt_q;
  logic             zero_q;

  function automatic logic [ASumW+DivW:0] dstep(logic [ASumW:0] p, logic [DivW-1:0] q,
                                              logic [ASumW-1:0] d);
    logic [ASumW+1:0] t;
    logic [ASumW+1:0] s;
    t = {p, q[DivW-1]};
    s = t - {2'b00, d};
    if (!s[ASumW+1]) return {s[ASumW:0], q[DivW-2:0], 1'b1};
    return {t[ASumW:0], q[DivW-2:0], 1'b0};
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      qr_q <= {rn, 8'd0}; qg_q <= {gn, 8'd0}; qb_q <= {bn, 8'd0};
      pr_q <= '0; pg_q <= '0; pb_q <= '0;
      den_q <= an; zero_q <= (an == '0); cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      {pr_q, qr_q} <= dstep(pr_q, qr_q, den_q);
      {pg_q, qg_q} <= dstep(pg_q, qg_q, den_q);
      {pb_q, qb_q} <= dstep(pb_q, qb_q, den_q);
      cnt_q <= cnt_q + 6'd1;
    end
  end
  assign status_o.div_done = zero_q || (cnt_q == 6'(DivW));

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      result_o.tile_number       <= tnum_q;
      result_o.avg_red           <= zero_q ? HalfGray : qr_q[15:0];
      result_o.avg_green         <= zero_q ? HalfGray : qg_q[15:0];
      result_o.avg_blue          <= zero_q ? HalfGray : qb_q[15:0];
      result_o.fully_transparent <= zero_q;
      result_o.final_tile        <= fin_q;
    end
  end
endmodule

[rtl/tawac_ctrl.sv]
module tawac_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  logic                  cfg_hit_i,
  input  tawac_pkg::dp_status_t status_i,
  output tawac_pkg::dp_cmd_t    cmd_o
);
  import tawac_pkg::*;

  state_e state_q, state_d;
  logic   ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

  always_comb begin
    state_d    = state_q;
    ov_d       = ov_q && out_stall_i;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      StClear: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_done) state_d = StIdle;
      end
      StIdle: begin
        // with a zero register the request is taken and dropped
        in_stall_o = 1'b0;
        if (in_valid_i && !status_i.zero_reg) begin
          cmd_o.capture = 1'b1;
          state_d = StRead;
        end
      end
      StRead: begin
        if (status_i.in_tiles) begin
          cmd_o.read_sums = 1'b1;
          state_d = StAccum;
        end else begin
          state_d = StIdle;
        end
      end
      StAccum: begin
        if (status_i.tile_done) begin
          cmd_o.clear_col = 1'b1;
          cmd_o.div_start = 1'b1;
          state_d = StDivide;
        end else begin
          cmd_o.write_sums = 1'b1;
          state_d = StIdle;
        end
      end
      StDivide: begin
        if (status_i.div_done) state_d = StOutput;
        else cmd_o.div_step = 1'b1;
      end
      StOutput: begin
        if (!ov_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          ov_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    if (cfg_hit_i && state_q != StClear) state_d = StClear;
  end
endmodule
